// ===== src/tpc_pkg.sv =====
// shared types and constants for the three-point touch calibration block
package tpc_pkg;

  localparam int RAW_BITS  = 12;
  localparam int DISP_BITS = 10;
  localparam int COEF_BITS = 32;
  localparam int QUOT_BITS = 33;

  localparam logic [DISP_BITS-1:0] DISP_WIDTH_RST  = 10'd320;
  localparam logic [DISP_BITS-1:0] DISP_HEIGHT_RST = 10'd240;

  typedef enum logic {
    REG_DISP_WIDTH  = 1'b0,
    REG_DISP_HEIGHT = 1'b1
  } tpc_reg_e;

  typedef struct packed {
    logic [RAW_BITS-1:0] raw_x1;
    logic [RAW_BITS-1:0] raw_y1;
    logic [RAW_BITS-1:0] raw_x2;
    logic [RAW_BITS-1:0] raw_y2;
    logic [RAW_BITS-1:0] raw_x3;
    logic [RAW_BITS-1:0] raw_y3;
  } tpc_raw_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] coef_ax;
    logic signed [COEF_BITS-1:0] coef_bx;
    logic signed [COEF_BITS-1:0] coef_dx;
    logic signed [COEF_BITS-1:0] coef_ay;
    logic signed [COEF_BITS-1:0] coef_by;
    logic signed [COEF_BITS-1:0] coef_dy;
    logic                        degenerate;
  } tpc_coef_t;

endpackage

// ===== src/tpc_div.sv =====
// pipelined signed fixed-point divider lane, one quotient bit per stage, saturating
module tpc_div import tpc_pkg::*; #(
  parameter int NUMW      = 38,
  parameter int DENW      = 26,
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [NUMW-1:0] num_i,
  input  logic signed [DENW-1:0] den_i,
  output logic                   valid_o,
  output logic                   zero_o,
  output logic [COEF_BITS-1:0]   quot_o
);

  localparam int QB = QUOT_BITS;
  localparam int SH = QB - FRAC_BITS;
  localparam logic [QB-1:0] LIM_POS = 33'h0_7FFF_FFFF;
  localparam logic [QB-1:0] LIM_NEG = 33'h0_8000_0000;

  logic [NUMW-1:0]           n_mag;
  logic [DENW-1:0]           d_mag;
  logic [NUMW-1:0]           hi;
  logic [NUMW+FRAC_BITS-1:0] nsh;

  assign n_mag = num_i[NUMW-1] ? NUMW'(-num_i) : NUMW'(num_i);
  assign d_mag = den_i[DENW-1] ? DENW'(-den_i) : DENW'(den_i);
  assign hi    = n_mag >> SH;
  assign nsh   = {n_mag, {FRAC_BITS{1'b0}}};

  logic            vld_q  [QB+1];
  logic [DENW-1:0] rem_q  [QB+1];
  logic [QB-1:0]   low_q  [QB+1];
  logic [QB-1:0]   quo_q  [QB+1];
  logic [DENW-1:0] d_q    [QB+1];
  logic            neg_q  [QB+1];
  logic            ovf_q  [QB+1];
  logic            zero_q [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= hi[DENW-1:0];
    low_q[0]  <= nsh[QB-1:0];
    quo_q[0]  <= '0;
    d_q[0]    <= d_mag;
    neg_q[0]  <= num_i[NUMW-1] ^ den_i[DENW-1];
    ovf_q[0]  <= hi >= NUMW'(d_mag);
    zero_q[0] <= d_mag == '0;
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [DENW:0]   trial;
    logic            ge;
    logic [DENW:0]   diff;

    assign trial = {rem_q[k-1], low_q[k-1][QB-1]};
    assign ge    = trial >= {1'b0, d_q[k-1]};
    assign diff  = trial - {1'b0, d_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
      low_q[k]  <= {low_q[k-1][QB-2:0], 1'b0};
      quo_q[k]  <= {quo_q[k-1][QB-2:0], ge};
      d_q[k]    <= d_q[k-1];
      neg_q[k]  <= neg_q[k-1];
      ovf_q[k]  <= ovf_q[k-1];
      zero_q[k] <= zero_q[k-1];
    end
  end

  logic [QB-1:0]        lim;
  logic [QB-1:0]        sel;
  logic [COEF_BITS-1:0] res;

  assign lim = neg_q[QB] ? LIM_NEG : LIM_POS;
  assign sel = (ovf_q[QB] || quo_q[QB] > lim) ? lim : quo_q[QB];
  assign res = zero_q[QB] ? '0
             : (neg_q[QB] ? -sel[COEF_BITS-1:0] : sel[COEF_BITS-1:0]);

  logic                 valid_q;
  logic                 zero_out_q;
  logic [COEF_BITS-1:0] quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    zero_out_q <= zero_q[QB];
    quot_q     <= res;
  end

  assign valid_o = valid_q;
  assign zero_o  = zero_out_q;
  assign quot_o  = quot_q;

  // partial remainder stays below the divisor when no overflow and the divisor is nonzero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[QB] && !ovf_q[QB] && !zero_q[QB] |-> rem_q[QB] < d_q[QB])
    else $error("divider remainder not below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == ($past(valid_i, QB + 2) === 1'b1))
    else $error("divider valid lost or invented");

endmodule

// ===== src/touch_three_point_calibration.sv =====
// top level: three-point touch calibration, determinant quotients in fixed point
// result: strobe done_o rises for each start that is taken, once it has passed all arithmetic and divider stages
// throughput: one transfer per cycle, busy stays low; five arithmetic stages feed
// six 35-stage divider lanes, one quotient bit per stage between the lane's input and output registers
// reset: pipeline empties, display size returns to 320 x 240
// results cannot be held off and leave on done_o for one cycle each
module touch_three_point_calibration import tpc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  tpc_raw_t        raw_i,
  output logic            done_o,
  output tpc_coef_t       coef_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int R    = RAW_BITS;
  localparam int DW   = 2 * R + 2;
  localparam int PW   = R + 13;
  localparam int CW   = 2 * R + 1;
  localparam int MW   = 2 * R + 12;
  localparam int NUMW = 2 * R + 14;
  localparam int LAT  = 5 + QUOT_BITS + 2;

  // configuration
  logic [DISP_BITS-1:0] disp_w_q, disp_h_q;
  logic                 wr_en;
  tpc_reg_e             wr_reg;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_reg = tpc_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_w_q <= DISP_WIDTH_RST;
      disp_h_q <= DISP_HEIGHT_RST;
    end else if (wr_en) begin
      unique case (wr_reg)
        REG_DISP_WIDTH:  disp_w_q <= pwdata[DISP_BITS-1:0];
        REG_DISP_HEIGHT: disp_h_q <= pwdata[DISP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_reg)
      REG_DISP_WIDTH:  prdata = 32'(disp_w_q);
      REG_DISP_HEIGHT: prdata = 32'(disp_h_q);
      default:         prdata = '0;
    endcase
  end

  // stage 1: capture raw points, place reference points
  logic                 accept;
  logic [DISP_BITS+1:0] w3, h3;

  assign accept = start && !busy;
  assign w3     = {2'b00, disp_w_q} + {1'b0, disp_w_q, 1'b0};
  assign h3     = {2'b00, disp_h_q} + {1'b0, disp_h_q, 1'b0};

  logic                 v1_q;
  tpc_raw_t             raw_q;
  logic [DISP_BITS-1:0] px1_q, px2_q, py1_q, py2_q, py3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q <= raw_i;
    px1_q <= disp_w_q >> 2;
    px2_q <= w3[DISP_BITS+1:2];
    py1_q <= disp_h_q >> 1;
    py2_q <= disp_h_q >> 2;
    py3_q <= h3[DISP_BITS+1:2];
  end

  // stage 2: differences and products
  logic signed [R:0]         dx13, dx23, dy13, dy23;
  logic signed [DISP_BITS:0] dpx13, dpx23, dpy13, dpy23;
  logic [DISP_BITS-1:0]      px3;

  assign px3   = px2_q;
  assign dx13  = $signed({1'b0, raw_q.raw_x1}) - $signed({1'b0, raw_q.raw_x3});
  assign dx23  = $signed({1'b0, raw_q.raw_x2}) - $signed({1'b0, raw_q.raw_x3});
  assign dy13  = $signed({1'b0, raw_q.raw_y1}) - $signed({1'b0, raw_q.raw_y3});
  assign dy23  = $signed({1'b0, raw_q.raw_y2}) - $signed({1'b0, raw_q.raw_y3});
  assign dpx13 = $signed({1'b0, px1_q}) - $signed({1'b0, px3});
  assign dpx23 = $signed({1'b0, px2_q}) - $signed({1'b0, px3});
  assign dpy13 = $signed({1'b0, py1_q}) - $signed({1'b0, py3_q});
  assign dpy23 = $signed({1'b0, py2_q}) - $signed({1'b0, py3_q});

  logic                 v2_q;
  logic signed [DW-1:0] da_q, db_q;
  logic signed [PW-1:0] n0a_q, n0b_q, n1a_q, n1b_q, n3a_q, n3b_q, n4a_q, n4b_q;
  logic [2*R-1:0]       c1a_q, c1b_q, c2a_q, c2b_q, c3a_q, c3b_q;
  logic [DISP_BITS-1:0] px1_2q, px2_2q, py1_2q, py2_2q, py3_2q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    da_q   <= dx13 * dy23;
    db_q   <= dx23 * dy13;
    n0a_q  <= dpx13 * dy23;
    n0b_q  <= dpx23 * dy13;
    n1a_q  <= dx13 * dpx23;
    n1b_q  <= dx23 * dpx13;
    n3a_q  <= dpy13 * dy23;
    n3b_q  <= dpy23 * dy13;
    n4a_q  <= dx13 * dpy23;
    n4b_q  <= dx23 * dpy13;
    c1a_q  <= raw_q.raw_x2 * raw_q.raw_y3;
    c1b_q  <= raw_q.raw_x3 * raw_q.raw_y2;
    c2a_q  <= raw_q.raw_x1 * raw_q.raw_y3;
    c2b_q  <= raw_q.raw_x3 * raw_q.raw_y1;
    c3a_q  <= raw_q.raw_x1 * raw_q.raw_y2;
    c3b_q  <= raw_q.raw_x2 * raw_q.raw_y1;
    px1_2q <= px1_q;
    px2_2q <= px2_q;
    py1_2q <= py1_q;
    py2_2q <= py2_q;
    py3_2q <= py3_q;
  end

  // stage 3: determinant, gain numerators, cofactors
  logic                 v3_q;
  logic signed [DW-1:0] det3_q;
  logic signed [PW:0]   num0_3q, num1_3q, num3_3q, num4_3q;
  logic signed [CW-1:0] c1_q, c2_q, c3_q;
  logic [DISP_BITS-1:0] px1_3q, px2_3q, py1_3q, py2_3q, py3_3q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    det3_q  <= da_q - db_q;
    num0_3q <= (PW+1)'(n0a_q) - (PW+1)'(n0b_q);
    num1_3q <= (PW+1)'(n1a_q) - (PW+1)'(n1b_q);
    num3_3q <= (PW+1)'(n3a_q) - (PW+1)'(n3b_q);
    num4_3q <= (PW+1)'(n4a_q) - (PW+1)'(n4b_q);
    c1_q    <= $signed({1'b0, c1a_q}) - $signed({1'b0, c1b_q});
    c2_q    <= $signed({1'b0, c2a_q}) - $signed({1'b0, c2b_q});
    c3_q    <= $signed({1'b0, c3a_q}) - $signed({1'b0, c3b_q});
    px1_3q  <= px1_2q;
    px2_3q  <= px2_2q;
    py1_3q  <= py1_2q;
    py2_3q  <= py2_2q;
    py3_3q  <= py3_2q;
  end

  // stage 4: offset products
  logic signed [DISP_BITS:0] spx1, spx2, spx3, spy1, spy2, spy3;

  assign spx1 = $signed({1'b0, px1_3q});
  assign spx2 = $signed({1'b0, px2_3q});
  assign spx3 = $signed({1'b0, px2_3q});
  assign spy1 = $signed({1'b0, py1_3q});
  assign spy2 = $signed({1'b0, py2_3q});
  assign spy3 = $signed({1'b0, py3_3q});

  logic                 v4_q;
  logic signed [DW-1:0] det4_q;
  logic signed [PW:0]   num0_4q, num1_4q, num3_4q, num4_4q;
  logic signed [MW-1:0] mx1_q, mx2_q, mx3_q, my1_q, my2_q, my3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    det4_q  <= det3_q;
    num0_4q <= num0_3q;
    num1_4q <= num1_3q;
    num3_4q <= num3_3q;
    num4_4q <= num4_3q;
    mx1_q   <= spx1 * c1_q;
    mx2_q   <= spx2 * c2_q;
    mx3_q   <= spx3 * c3_q;
    my1_q   <= spy1 * c1_q;
    my2_q   <= spy2 * c2_q;
    my3_q   <= spy3 * c3_q;
  end

  // stage 5: offset sums, divider operands
  logic                   v5_q;
  logic signed [DW-1:0]   det5_q;
  logic signed [NUMW-1:0] num5_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    det5_q    <= det4_q;
    num5_q[0] <= NUMW'(num0_4q);
    num5_q[1] <= NUMW'(num1_4q);
    num5_q[2] <= NUMW'(mx1_q) - NUMW'(mx2_q) + NUMW'(mx3_q);
    num5_q[3] <= NUMW'(num3_4q);
    num5_q[4] <= NUMW'(num4_4q);
    num5_q[5] <= NUMW'(my1_q) - NUMW'(my2_q) + NUMW'(my3_q);
  end

  // divider lanes
  logic                 lane_vld  [6];
  logic                 lane_zero [6];
  logic [COEF_BITS-1:0] lane_quot [6];

  for (genvar i = 0; i < 6; i++) begin : g_lane
    tpc_div #(
      .NUMW      (NUMW),
      .DENW      (DW),
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v5_q),
      .num_i   (num5_q[i]),
      .den_i   (det5_q),
      .valid_o (lane_vld[i]),
      .zero_o  (lane_zero[i]),
      .quot_o  (lane_quot[i])
    );
  end

  assign done_o            = lane_vld[0];
  assign coef_o.coef_ax    = lane_quot[0];
  assign coef_o.coef_bx    = lane_quot[1];
  assign coef_o.coef_dx    = lane_quot[2];
  assign coef_o.coef_ay    = lane_quot[3];
  assign coef_o.coef_by    = lane_quot[4];
  assign coef_o.coef_dy    = lane_quot[5];
  assign coef_o.degenerate = lane_zero[0];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && coef_o.degenerate |->
      coef_o.coef_ax == '0 && coef_o.coef_bx == '0 && coef_o.coef_dx == '0 &&
      coef_o.coef_ay == '0 && coef_o.coef_by == '0 && coef_o.coef_dy == '0)
    else $error("degenerate result with nonzero coefficients");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(start && !busy, LAT))
    else $error("result strobe does not match accepted transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_vld[0] == lane_vld[5] && lane_zero[0] == lane_zero[5] &&
    lane_vld[1] == lane_vld[4] && lane_zero[2] == lane_zero[3])
    else $error("divider lanes out of step");

endmodule

// ===== tb/sv/tb_touch_three_point_calibration.sv =====
// testbench for the three-point touch calibration block: random and corner raw sets vs predictor
module tb_touch_three_point_calibration;
  import tpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [2:0] ADDR_WIDTH = 3'(4 * REG_DISP_WIDTH);
  localparam logic [2:0] ADDR_HEIGHT = 3'(4 * REG_DISP_HEIGHT);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  tpc_raw_t raw_i = '0;
  logic done_o;
  tpc_coef_t coef_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  touch_three_point_calibration dut (.*);

  tpc_raw_t pending_sets[$];
  tpc_coef_t expected_coefs[$];
  logic [9:0] width_q = DISP_WIDTH_RST, height_q = DISP_HEIGHT_RST;
  int mismatches = 0, transfers_in = 0, results_seen = 0, idle_cycles = 0;
  bit timed_out = 1'b0;
  bit sender_on = 1'b0;
  int burst_left = 0;

  initial forever #10 clk_i = ~clk_i;

  function automatic logic [31:0] sat_quotient(longint num, longint den);
    bit neg;
    longint unsigned n, d, q, r, mag, lim;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = n / d;
    r = n % d;
    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    if (q >= (64'd1 << 16)) mag = lim;
    else mag = (q << 16) + (r << 16) / d;
    if (mag > lim) mag = lim;
    if (neg) mag = -mag;
    return mag[31:0];
  endfunction

  function automatic tpc_coef_t calibrate(tpc_raw_t s);
    longint x1, y1, x2, y2, x3, y3, w, h, px1, py1, px2, py2, px3, py3;
    longint c1, c2, c3, det;
    longint num[6];
    tpc_coef_t c;
    x1 = s.raw_x1; y1 = s.raw_y1; x2 = s.raw_x2;
    y2 = s.raw_y2; x3 = s.raw_x3; y3 = s.raw_y3;
    w = width_q; h = height_q;
    px1 = w * 25 / 100; py1 = h * 50 / 100;
    px2 = w * 75 / 100; py2 = h * 25 / 100;
    px3 = w * 75 / 100; py3 = h * 75 / 100;
    c1 = x2 * y3 - x3 * y2;
    c2 = x1 * y3 - x3 * y1;
    c3 = x1 * y2 - x2 * y1;
    det = (x1 - x3) * (y2 - y3) - (x2 - x3) * (y1 - y3);
    num[0] = (px1 - px3) * (y2 - y3) - (px2 - px3) * (y1 - y3);
    num[1] = (x1 - x3) * (px2 - px3) - (x2 - x3) * (px1 - px3);
    num[2] = px1 * c1 - px2 * c2 + px3 * c3;
    num[3] = (py1 - py3) * (y2 - y3) - (py2 - py3) * (y1 - y3);
    num[4] = (x1 - x3) * (py2 - py3) - (x2 - x3) * (py1 - py3);
    num[5] = py1 * c1 - py2 * c2 + py3 * c3;
    c = '0;
    if (det == 0) begin
      c.degenerate = 1'b1;
    end else begin
      c.coef_ax = sat_quotient(num[0], det);
      c.coef_bx = sat_quotient(num[1], det);
      c.coef_dx = sat_quotient(num[2], det);
      c.coef_ay = sat_quotient(num[3], det);
      c.coef_by = sat_quotient(num[4], det);
      c.coef_dy = sat_quotient(num[5], det);
    end
    return c;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (burst_left > 0) begin
        burst_left <= burst_left - 1;
      end else begin
        sender_on <= ~sender_on;
        burst_left <= (!sender_on) ? $urandom_range(1, 30) :
                      ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
      end
      if (pending_sets.size() > 0 && (sender_on || (start && busy))) begin
        start <= 1'b1;
        raw_i <= pending_sets[0];
      end else begin
        start <= 1'b0;
        raw_i <= tpc_raw_t'(72'({$urandom, $urandom, $urandom}));
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (start && !busy) begin
        expected_coefs.push_back(calibrate(raw_i));
        void'(pending_sets.pop_front());
        transfers_in <= transfers_in + 1;
      end
      if (done_o) begin
        results_seen <= results_seen + 1;
        if (expected_coefs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", coef_o);
        end else begin
          tpc_coef_t e;
          e = expected_coefs.pop_front();
          if (coef_o !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", e, coef_o);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("watchdog expired");
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_WIDTH) width_q = data[9:0];
    else if (addr == ADDR_HEIGHT) height_q = data[9:0];
  endtask

  task automatic drain();
    while (pending_sets.size() > 0 || expected_coefs.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic logic [11:0] raw_value();
    case ($urandom_range(0, 5))
      0: return 12'd0;
      1: return 12'hfff;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic tpc_raw_t random_set();
    tpc_raw_t s;
    int kind;
    s = '{raw_value(), raw_value(), raw_value(), raw_value(), raw_value(), raw_value()};
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      s.raw_x2 = s.raw_x1; s.raw_y2 = s.raw_y1;
    end else if (kind == 1) begin
      s.raw_x1 = s.raw_x3 + 12'($urandom_range(0, 2));
      s.raw_y1 = s.raw_y3 + 12'($urandom_range(0, 2));
      s.raw_x2 = s.raw_x3 + 12'($urandom_range(0, 2));
      s.raw_y2 = s.raw_y3 + 12'($urandom_range(0, 2));
    end else if (kind < 6) begin
      // typical panel: points placed roughly where a touch would land
      s.raw_x1 = 12'($urandom_range(500, 1500));
      s.raw_x2 = 12'($urandom_range(2600, 3600));
      s.raw_x3 = s.raw_x2 + 12'($urandom_range(0, 200)) - 12'd100;
      s.raw_y1 = 12'($urandom_range(1500, 2600));
      s.raw_y2 = 12'($urandom_range(500, 1500));
      s.raw_y3 = 12'($urandom_range(2600, 3600));
    end
    return s;
  endfunction

  initial begin
    logic [9:0] widths[5];
    logic [9:0] heights[5];
    widths = '{10'd1, 10'd1023, 10'd0, 10'd640, 10'd320};
    heights = '{10'd1023, 10'd1, 10'd0, 10'd480, 10'd240};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed corners at reset size
    pending_sets.push_back('0);
    pending_sets.push_back('1);
    pending_sets.push_back('{12'd0, 12'd2048, 12'd4095, 12'd0, 12'd4095, 12'd4095});
    pending_sets.push_back('{12'd1000, 12'd2000, 12'd3000, 12'd1000, 12'd3000, 12'd3000});
    pending_sets.push_back('{12'd3000, 12'd2000, 12'd1000, 12'd1000, 12'd1000, 12'd3000});
    pending_sets.push_back('{12'd100, 12'd100, 12'd101, 12'd100, 12'd100, 12'd101});
    pending_sets.push_back('{12'd4095, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd0});
    pending_sets.push_back('{12'd1, 12'd2, 12'd2, 12'd4, 12'd3, 12'd6});
    pending_sets.push_back('{12'd2000, 12'd2001, 12'd2000, 12'd2000, 12'd2001, 12'd2000});
    pending_sets.push_back('{12'haaa, 12'h555, 12'h555, 12'haaa, 12'haaa, 12'haaa});
    drain();
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 2) write_reg(3'd4, $urandom);
      write_reg(ADDR_WIDTH, {$urandom} << 10 | 32'(widths[phase]));
      write_reg(ADDR_HEIGHT, {$urandom} << 10 | 32'(heights[phase]));
      for (int i = 0; i < 270; i++) pending_sets.push_back(random_set());
      drain();
    end
    $display("covered %0d transfers, %0d results over five display sizes",
             transfers_in, results_seen);
    if (mismatches == 0 && expected_coefs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
src/tpc_pkg.sv
src/tpc_div.sv
src/touch_three_point_calibration.sv
tb/sv/tb_touch_three_point_calibration.sv
